@@ src/plid_pkg.sv @@
`timescale 1ns / 1ps
package plid_pkg;

   // Default list capacity in entries.
   localparam int CAPACITY_DEFAULT = 32;

   // Field widths.
   localparam int KIND_W   = 2;
   localparam int POS_W    = 6;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;

   // Operation kinds carried on the request tuser.
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

   // Move that the cell row makes in one cycle.
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_DELETE
   } op_type;

   // Control broadcast from the top level to every cell.
   typedef struct packed {
      op_type                    op;
      logic [POS_W-1:0]          pos_idx;
      logic signed [WORD_W-1:0]  value;
   } ctrl_type;

endpackage

@@ src/plid_cell.sv @@
`timescale 1ns / 1ps
module plid_cell #(
   parameter int INDEX = 0
) (
   input  logic                            clock,
   input  plid_pkg::ctrl_type              ctrl,
   input  logic [plid_pkg::WORD_W-1:0]     left_value,
   input  logic [plid_pkg::WORD_W-1:0]     right_value,
   output logic [plid_pkg::WORD_W-1:0]     entry,
   output logic [plid_pkg::WORD_W-1:0]     read_word
);
   import plid_pkg::*;

   // Low bits of the cell index; cells at 64 and beyond sit past every position.
   localparam logic [POS_W-1:0] IDX_LOW  = POS_W'(INDEX % 64);
   localparam bit               IDX_HIGH = (INDEX >= 64);

   logic [WORD_W-1:0] entry_ff;
   logic [WORD_W-1:0] entry_in;
   logic              hit;
   logic              above;

   // Where this cell stands relative to the addressed position.
   assign hit   = !IDX_HIGH && (IDX_LOW == ctrl.pos_idx);
   assign above = IDX_HIGH || (IDX_LOW > ctrl.pos_idx);

   // Insert takes the word at the position and the left neighbor above it;
   // delete takes the right neighbor at and above the position.
   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (hit) begin
               entry_in = ctrl.value;
            end else if (above) begin
               entry_in = left_value;
            end
         end
         OP_DELETE: begin
            if (hit || above) begin
               entry_in = right_value;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry     = entry_ff;
   assign read_word = hit ? entry_ff : '0;

endmodule

@@ src/positional_list_insert_delete.sv @@
`timescale 1ns / 1ps
// Result: the result word is registered at the edge that accepts the request word.
// Throughput: one word per cycle while the result is taken; every cell of the row shifts
// in the same cycle, and the result register is refilled as it drains.
// Reset: synchronous, active high; empties the list and drops any pending result.
// Entry contents are not cleared; only positions up to the length are ever read.
module positional_list_insert_delete #(
   parameter int CAPACITY = plid_pkg::CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [5:0] position, [37:6] value, [39:38] zero
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [1:0] status, [33:2] read_value, [39:34] count
);
   import plid_pkg::*;

   localparam int USED_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W     = ((USED_W > POS_W) ? USED_W : POS_W) + 1;
   localparam int READ_SPAN = (CAPACITY < 63) ? CAPACITY : 63;

   logic [USED_W-1:0]   used_ff;
   logic [USED_W-1:0]   used_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [39:0]         rsp_data_ff;
   logic [39:0]         rsp_data_in;

   logic                accept;
   logic [KIND_W-1:0]   kind;
   logic [POS_W-1:0]    position;
   logic [WORD_W-1:0]   value;
   logic [CMP_W-1:0]    pos_w;
   logic [CMP_W-1:0]    used_w;
   logic [CMP_W-1:0]    count_w;
   logic                pos_zero;
   logic                ins_bad;
   logic                sel_bad;
   logic                full;
   logic [STATUS_W-1:0] status;
   logic [WORD_W-1:0]   read_value;
   logic [WORD_W-1:0]   read_any;
   ctrl_type            ctrl;

   logic [WORD_W-1:0]   cell_entry [CAPACITY];
   logic [WORD_W-1:0]   cell_read  [CAPACITY];

   // Unpack the request word.
   assign kind     = req_tuser[KIND_W-1:0];
   assign position = req_tdata[POS_W-1:0];
   assign value    = req_tdata[POS_W+WORD_W-1:POS_W];

   // A new word enters whenever the result register is free or draining.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Position checks against the current length.
   assign pos_w    = CMP_W'(position);
   assign used_w   = CMP_W'(used_ff);
   assign pos_zero = (position == '0);
   assign ins_bad  = pos_zero || (pos_w > used_w + CMP_W'(1));
   assign sel_bad  = pos_zero || (pos_w > used_w);
   assign full     = (used_w == CMP_W'(CAPACITY));

   // Gather the addressed entry; only the first 63 cells are reachable.
   always_comb begin
      read_any = '0;
      for (int i = 0; i < READ_SPAN; i++) begin
         read_any = read_any | cell_read[i];
      end
   end

   // Decide the operation, its status and the new length.
   always_comb begin
      ctrl.op      = OP_HOLD;
      ctrl.pos_idx = position - POS_W'(1);
      ctrl.value   = value;
      status       = ST_DONE;
      read_value   = '0;
      used_in      = used_ff;
      case (kind)
         KIND_INSERT: begin
            if (ins_bad) begin
               status = ST_BADPOS;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               ctrl.op = OP_INSERT;
               used_in = used_ff + USED_W'(1);
            end
         end
         KIND_DELETE: begin
            if (sel_bad) begin
               status = ST_BADPOS;
            end else begin
               ctrl.op = OP_DELETE;
               used_in = used_ff - USED_W'(1);
            end
         end
         KIND_READ: begin
            if (sel_bad) begin
               status = ST_BADPOS;
            end else begin
               read_value = read_any;
            end
         end
         KIND_CLEAR: begin
            used_in = '0;
         end
         default: begin
            used_in = used_ff;
         end
      endcase
      if (!accept) begin
         ctrl.op = OP_HOLD;
         used_in = used_ff;
      end
   end

   assign count_w = CMP_W'(used_in);

   // Result register: loads on accept, empties when taken.
   always_comb begin
      rsp_data_in  = {count_w[COUNT_W-1:0], read_value, status};
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The row of entry cells, each linked to both neighbors.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [WORD_W-1:0] left_value;
      logic [WORD_W-1:0] right_value;

      if (g == 0) begin : g_first
         assign left_value = cell_entry[g];
      end else begin : g_inner_l
         assign left_value = cell_entry[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_value = cell_entry[g];
      end else begin : g_inner_r
         assign right_value = cell_entry[g+1];
      end

      plid_cell #(
         .INDEX (g)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .left_value  (left_value),
         .right_value (right_value),
         .entry       (cell_entry[g]),
         .read_word   (cell_read[g])
      );
   end

endmodule

@@ src/plid_checker.sv @@
`timescale 1ns / 1ps
module plid_checker #(
   parameter int CAPACITY = plid_pkg::CAPACITY_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   import plid_pkg::*;

   // A result word that is not taken holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // Every accepted request word shows a result in the next cycle.
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request gave no result");

   // Only the three defined status codes appear.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == ST_DONE) || (rsp_tdata[1:0] == ST_BADPOS)
                     || (rsp_tdata[1:0] == ST_FULL))
      else $error("undefined status code");

   // A failed operation never carries a read value.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != ST_DONE) |-> (rsp_tdata[33:2] == '0))
      else $error("read value on failed operation");

   // The reported length never exceeds the capacity; checked only for a capacity of 63 or less.
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (CAPACITY > 63) || (int'(rsp_tdata[39:34]) <= CAPACITY))
      else $error("length above capacity");

endmodule

bind positional_list_insert_delete plid_checker #(.CAPACITY(CAPACITY)) u_plid_checker (.*);
